@@ hw/rtl/uer_pkg.sv @@
// Shared widths, reset values, register indexes and command/status types for the echo ranger.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  localparam int unsigned PeriodW  = 24;
  localparam int unsigned PulseW   = 16;
  localparam int unsigned TimeoutW = 24;
  localparam int unsigned AcceptW  = 24;
  localparam int unsigned TpcW     = 16;
  localparam int unsigned RangeW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [PeriodW-1:0]  PeriodReset  = 24'd2500000;
  localparam logic [PulseW-1:0]   PulseReset   = 16'd500;
  localparam logic [TimeoutW-1:0] TimeoutReset = 24'd1500000;
  localparam logic [AcceptW-1:0]  AcceptReset  = 24'd1299999;
  localparam logic [TpcW-1:0]     TpcReset     = 16'd2900;

  // Distance reported for an accepted echo when the divisor is zero.
  localparam logic [RangeW-1:0] RangeAllOnes = {RangeW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriod  = 3'd0,
    CfgPulse   = 3'd1,
    CfgTimeout = 3'd2,
    CfgAccept  = 3'd3,
    CfgTpc     = 3'd4
  } cfg_index_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;       // an input transfer happens this cycle
    logic div_start;  // launch the divider on this tick's echo length
    logic commit;     // divider finished: store the distance and present the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;   // the offered tick ends an accepted echo with a nonzero divisor
    logic div_done;   // quotient is ready
    logic out_free;   // output register can take a new result this cycle
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/uer_div.sv @@
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module uer_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [uer_pkg::RangeW-1:0]    dividend_i,
  input  logic [uer_pkg::TpcW-1:0]      divisor_i,
  output logic [uer_pkg::RangeW-1:0]    quotient_o,
  output logic                          done_o
);

  localparam int unsigned Steps = uer_pkg::RangeW;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned DW    = uer_pkg::TpcW;

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [uer_pkg::RangeW-1:0] quo_q;
  logic [DW-1:0]              rem_q;
  logic [DW-1:0]              div_q;

  logic [DW+1:0] diff;
  logic          fits;
  logic          stepping;

  // Shifted partial remainder minus divisor; the top bit is the borrow.
  assign diff     = {1'b0, rem_q, quo_q[uer_pkg::RangeW-1]} - {2'b00, div_q};
  assign fits     = ~diff[DW+1];
  assign stepping = busy_q && (cnt_q != '0);

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Steps);
    end else if (stepping) begin
      cnt_d = cnt_q - CntW'(1);
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (stepping) begin
      // The remainder stays below the divisor, so its low bits always suffice.
      if (fits) begin
        rem_q <= diff[DW-1:0];
      end else begin
        rem_q <= {rem_q[DW-2:0], quo_q[uer_pkg::RangeW-1]};
      end
      quo_q <= {quo_q[uer_pkg::RangeW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/uer_datapath.sv @@
// Timing counters, configuration registers, distance logic and output register.
`timescale 1ns / 1ps
`default_nettype none

module uer_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  uer_pkg::cmd_t                 cmd_i,
  output uer_pkg::stat_t                stat_o,
  input  logic                          cfg_valid_i,
  input  logic [uer_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [uer_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          echo_level_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          trigger_level_o,
  output logic [uer_pkg::RangeW-1:0]    range_cm_o,
  output logic                          range_updated_o
);

  // Configuration registers.
  logic [uer_pkg::PeriodW-1:0]  period_ticks_q;
  logic [uer_pkg::PulseW-1:0]   pulse_ticks_q;
  logic [uer_pkg::TimeoutW-1:0] timeout_ticks_q;
  logic [uer_pkg::AcceptW-1:0]  accept_max_q;
  logic [uer_pkg::TpcW-1:0]     ticks_per_cm_q;

  // Tick state.
  logic [uer_pkg::PeriodW-1:0]  period_count_q, period_count_d;
  logic                         pulse_active_q, pulse_active_d;
  logic [uer_pkg::PulseW-1:0]   pulse_count_q, pulse_count_d;
  logic                         echo_running_q, echo_running_d;
  logic [uer_pkg::RangeW-1:0]   echo_elapsed_q, echo_elapsed_d;
  logic                         echo_prev_q;
  logic [uer_pkg::RangeW-1:0]   range_value_q, range_value_d;

  // Output register.
  logic                         out_valid_q;
  logic                         out_trigger_q;
  logic [uer_pkg::RangeW-1:0]   out_range_q;
  logic                         out_updated_q;

  logic [uer_pkg::PulseW-1:0]   pulse_inc;
  logic [uer_pkg::PeriodW-1:0]  period_inc;
  logic [uer_pkg::RangeW-1:0]   elapsed_inc;
  logic                         fall, rise, over_limit, need_div, updated;
  logic                         out_taken, load_tick;

  logic [uer_pkg::RangeW-1:0]   quotient;
  logic                         div_done;

  always_comb begin
    pulse_active_d = pulse_active_q;
    pulse_count_d  = pulse_count_q;
    pulse_inc      = pulse_count_q + 16'd1;
    if (pulse_active_q) begin
      pulse_count_d = pulse_inc;
      if ((pulse_inc >= pulse_ticks_q) || (pulse_inc == '0)) begin
        pulse_active_d = 1'b0;
      end
    end

    // A new period does not restart a pulse that is still high.
    period_inc     = period_count_q + 24'd1;
    period_count_d = period_inc;
    if ((period_inc >= period_ticks_q) || (period_inc == '0)) begin
      period_count_d = '0;
      if (!pulse_active_d) begin
        pulse_active_d = 1'b1;
        pulse_count_d  = '0;
      end
    end

    // The timeout is checked before the echo edges of the same tick.
    echo_running_d = echo_running_q;
    echo_elapsed_d = echo_elapsed_q;
    elapsed_inc    = echo_elapsed_q + 24'd1;
    if (echo_running_q) begin
      echo_elapsed_d = elapsed_inc;
      if ((elapsed_inc >= timeout_ticks_q) || (elapsed_inc == '0)) begin
        echo_running_d = 1'b0;
      end
    end

    fall       = !echo_level_i && echo_prev_q && echo_running_d;
    rise       = echo_level_i && !echo_prev_q && !echo_running_d;
    over_limit = echo_elapsed_d > accept_max_q;
    need_div   = 1'b0;
    updated    = 1'b0;
    range_value_d = range_value_q;

    if (fall) begin
      updated = 1'b1;
      if (over_limit) begin
        range_value_d = '0;
      end else if (ticks_per_cm_q == '0) begin
        range_value_d = uer_pkg::RangeAllOnes;
      end else begin
        need_div = 1'b1;
      end
    end else if (rise) begin
      echo_running_d = 1'b1;
      echo_elapsed_d = '0;
    end
  end

  uer_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (echo_elapsed_d),
    .divisor_i  (ticks_per_cm_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign out_taken = out_valid_q && !out_stall_i;
  assign load_tick = cmd_i.tick && !need_div;

  assign stat_o.need_div = need_div;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ticks_q  <= uer_pkg::PeriodReset;
      pulse_ticks_q   <= uer_pkg::PulseReset;
      timeout_ticks_q <= uer_pkg::TimeoutReset;
      accept_max_q    <= uer_pkg::AcceptReset;
      ticks_per_cm_q  <= uer_pkg::TpcReset;
    end else if (cfg_valid_i) begin
      case (uer_pkg::cfg_index_e'(cfg_index_i))
        uer_pkg::CfgPeriod:  period_ticks_q  <= cfg_data_i;
        uer_pkg::CfgPulse:   pulse_ticks_q   <= cfg_data_i[uer_pkg::PulseW-1:0];
        uer_pkg::CfgTimeout: timeout_ticks_q <= cfg_data_i;
        uer_pkg::CfgAccept:  accept_max_q    <= cfg_data_i;
        uer_pkg::CfgTpc:     ticks_per_cm_q  <= cfg_data_i[uer_pkg::TpcW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_count_q <= '0;
      pulse_active_q <= 1'b0;
      pulse_count_q  <= '0;
      echo_running_q <= 1'b0;
      echo_elapsed_q <= '0;
      echo_prev_q    <= 1'b0;
      range_value_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        period_count_q <= period_count_d;
        pulse_active_q <= pulse_active_d;
        pulse_count_q  <= pulse_count_d;
        echo_running_q <= echo_running_d;
        echo_elapsed_q <= echo_elapsed_d;
        echo_prev_q    <= echo_level_i;
        range_value_q  <= range_value_d;
      end else if (cmd_i.commit) begin
        range_value_q <= quotient;
      end
      if (load_tick || cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_tick) begin
      out_trigger_q <= pulse_active_d;
      out_range_q   <= range_value_d;
      out_updated_q <= updated;
    end else if (cmd_i.commit) begin
      out_trigger_q <= pulse_active_q;
      out_range_q   <= quotient;
      out_updated_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = out_trigger_q;
  assign range_cm_o      = out_range_q;
  assign range_updated_o = out_updated_q;

endmodule

`default_nettype wire

@@ hw/rtl/uer_ctrl.sv @@
// Controller sequencing tick transfers and distance divisions.
`timescale 1ns / 1ps
`default_nettype none

module uer_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  uer_pkg::stat_t  stat_i,
  output uer_pkg::cmd_t   cmd_o
);

  typedef enum logic [0:0] {
    StIdle,
    StDivide
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_stall_o = !((state_q == StIdle) && stat_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.tick      = accept;
  assign cmd_o.div_start = accept && stat_i.need_div;
  assign cmd_o.commit    = (state_q == StDivide) && stat_i.div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept && stat_i.need_div) begin
            state_q <= StDivide;
          end
        end
        StDivide: begin
          if (stat_i.div_done) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ultrasonic_echo_ranging_core.sv @@
// Top level of the ultrasonic echo ranging core: controller plus datapath.
//
// Each input transfer is one tick of the timing base and carries the sampled
// echo pin level. Every accepted tick yields exactly one result transfer with
// the trigger pin level, the stored distance in centimetres and a flag that
// marks the tick on which the distance was rewritten.
// Ordinary ticks give a valid result in the cycle after the input transfer and
// are accepted back to back, one per cycle, while the receiver does not stall.
// A tick that ends an accepted echo with a nonzero divisor runs the serial
// divider, one quotient bit per cycle, and the input is stalled until its
// result appears.
// Configuration writes are always ready and take effect on the next cycle;
// they are meant to be issued while the core is idle. Unknown indexes are
// dropped. Reset loads the default register values and clears all counters,
// the echo timer, the stored distance and the output valid flag. When the
// receiver stalls, the result holds and the input is stalled until it leaves.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranging_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Tick input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          echo_level_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trigger_level_o,
  output logic [uer_pkg::RangeW-1:0]    range_cm_o,
  output logic                          range_updated_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [uer_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [uer_pkg::CfgDataW-1:0]  cfg_data_i
);

  uer_pkg::cmd_t  cmd;
  uer_pkg::stat_t stat;

  // Register writes need no wait state.
  assign cfg_ready_o = 1'b1;

  // The controller alone decides when a tick transfer happens and when a
  // finished quotient is committed.
  uer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the trigger and echo counters, the configuration
  // registers, the divider and the result register.
  uer_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .echo_level_i    (echo_level_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .trigger_level_o (trigger_level_o),
    .range_cm_o      (range_cm_o),
    .range_updated_o (range_updated_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/ultrasonic_echo_ranging_core_test.sv @@
// Self-checking testbench for the ultrasonic echo ranging core with a tick-by-tick predictor.
`timescale 1ns / 1ps

module ultrasonic_echo_ranging_core_test;
  import uer_pkg::*;

  // Index that names no register; a write to it must leave every setting alone.
  localparam logic [CfgIdxW-1:0] CfgNoReg = 3'd7;
  // A tick that ends an accepted echo holds its result back for the serial divide.
  localparam int DivLatency = 26;
  // Share of cycles in which each side idles, in percent.
  localparam int IdlePct = 27;
  localparam int RandomPhases = 8;
  localparam int TicksPerPhase = 150;

  // One result transfer: the trigger pin, the stored distance and the rewrite flag.
  typedef struct packed {
    logic              trig;
    logic [RangeW-1:0] range;
    logic              upd;
  } ranging_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                echo_level_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                trigger_level_o;
  logic [RangeW-1:0]   range_cm_o;
  logic                range_updated_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ultrasonic_echo_ranging_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .echo_level_i   (echo_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_level_o(trigger_level_o),
    .range_cm_o     (range_cm_o),
    .range_updated_o(range_updated_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // The predictor keeps its own copy of the five settings, loaded from the package
  // defaults and then updated on every configuration transfer the core takes.
  logic [PeriodW-1:0]  period_len  = PeriodReset;
  logic [PulseW-1:0]   pulse_len   = PulseReset;
  logic [TimeoutW-1:0] timeout_len = TimeoutReset;
  logic [AcceptW-1:0]  accept_max  = AcceptReset;
  logic [TpcW-1:0]     cm_div      = TpcReset;

  // Predicted core state; reset clears all of it.
  logic [PeriodW-1:0]  period_cnt  = '0;
  logic                pulse_on    = 1'b0;
  logic [PulseW-1:0]   pulse_cnt   = '0;
  logic                timer_on    = 1'b0;
  logic [TimeoutW-1:0] timer_ticks = '0;
  logic                echo_last   = 1'b0;
  logic [RangeW-1:0]   stored_cm   = '0;

  logic              pending_echo[$];     // echo levels still to be sent
  ranging_result_t   expected_results[$]; // predicted results not yet seen
  int                ticks_queued   = 0;
  int                ticks_accepted = 0;
  int                failures       = 0;
  logic              tick_taken     = 1'b0; // the last rising edge moved a tick
  logic              calm           = 1'b0; // no idling on either side while set

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Advances the predicted core by one tick and returns the result it gives. The
  // order matters: pulse counter, then period counter, then echo timer, then the
  // echo edges. All limits but the accept limit use greater-or-equal, so a limit
  // moved below a running count stops or wraps it on the next tick.
  function automatic ranging_result_t ranging_tick(input logic echo);
    ranging_result_t res;
    logic            upd;
    upd = 1'b0;
    if (pulse_on) begin
      pulse_cnt = pulse_cnt + 16'd1;
      if (pulse_cnt >= pulse_len || pulse_cnt == '0) pulse_on = 1'b0;
    end
    period_cnt = period_cnt + 24'd1;
    if (period_cnt >= period_len || period_cnt == '0) begin
      period_cnt = '0;
      // A period that starts during a pulse does not restart it.
      if (!pulse_on) begin
        pulse_on  = 1'b1;
        pulse_cnt = '0;
      end
    end
    // The timeout is handled before the edges, so a falling edge on the very
    // tick the timer expires is dropped.
    if (timer_on) begin
      timer_ticks = timer_ticks + 24'd1;
      if (timer_ticks >= timeout_len || timer_ticks == '0) timer_on = 1'b0;
    end
    if (!echo && echo_last && timer_on) begin
      // The timer keeps running after a falling edge it measured.
      if (timer_ticks > accept_max) stored_cm = '0;
      else if (cm_div == '0) stored_cm = RangeAllOnes;
      else stored_cm = timer_ticks / cm_div;
      upd = 1'b1;
    end else if (echo && !echo_last && !timer_on) begin
      timer_on    = 1'b1;
      timer_ticks = '0;
    end
    echo_last = echo;
    res.trig  = pulse_on;
    res.range = stored_cm;
    res.upd   = upd;
    return res;
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Tick driver: a new echo level goes out only once the previous tick has been
  // transferred; a stalled tick keeps its level.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || tick_taken)) begin
      if (pending_echo.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        in_valid_i   <= 1'b1;
        echo_level_i <= pending_echo.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && !calm && ($urandom_range(99) < IdlePct);
  end

  // Monitor: every tick transfer is run through the predictor, every result
  // transfer is compared against the oldest prediction.
  always @(posedge clk_i) begin
    ranging_result_t want;
    ranging_result_t got;
    if (rst_ni) begin
      tick_taken = in_valid_i && !in_stall_o;
      if (tick_taken) begin
        expected_results.push_back(ranging_tick(echo_level_i));
        ticks_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        got.trig  = trigger_level_o;
        got.range = range_cm_o;
        got.upd   = range_updated_o;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result with no tick waiting: trigger=%0d range=%0d updated=%0d",
                                   got.trig, got.range, got.upd));
        end else begin
          want = expected_results.pop_front();
          if (got.trig !== want.trig || got.range !== want.range || got.upd !== want.upd) begin
            report_failure($sformatf(
              "expected trigger=%0d range=%0d updated=%0d, got trigger=%0d range=%0d updated=%0d",
              want.trig, want.range, want.upd, got.trig, got.range, got.upd));
          end
        end
      end
    end
  end

  // A register write only lands in the predictor once the core has taken it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgPeriod:  period_len  = val[PeriodW-1:0];
      CfgPulse:   pulse_len   = val[PulseW-1:0];
      CfgTimeout: timeout_len = val[TimeoutW-1:0];
      CfgAccept:  accept_max  = val[AcceptW-1:0];
      CfgTpc:     cm_div      = val[TpcW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_ranging(input logic [PeriodW-1:0] per, input logic [PulseW-1:0] pul,
                             input logic [TimeoutW-1:0] tmo, input logic [AcceptW-1:0] acc,
                             input logic [TpcW-1:0] tpc);
    write_reg(CfgPeriod, per);
    write_reg(CfgPulse, pul);
    write_reg(CfgTimeout, tmo);
    write_reg(CfgAccept, acc);
    write_reg(CfgTpc, tpc);
  endtask

  task automatic queue_level(input logic lvl);
    pending_echo.push_back(lvl);
    ticks_queued++;
  endtask

  // Queues the n lowest bits of a pattern, most significant first.
  task automatic queue_pattern(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) queue_level(bits[i]);
  endtask

  // Waits until every queued tick has been transferred and its result has
  // come back, which leaves the core idle.
  task automatic drain();
    while (ticks_accepted != ticks_queued || expected_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int                  n;
    int                  len;
    logic [PeriodW-1:0]  per;
    logic [PulseW-1:0]   pul;
    logic [TimeoutW-1:0] tmo;
    logic [AcceptW-1:0]  acc;
    logic [TpcW-1:0]     tpc;

    wait (rst_ni);

    // Zero period, zero pulse length and zero timeout: a period starts on every
    // tick, each trigger pulse lasts one tick and restarts at once, and the timer
    // expires on the tick after a rising edge, which also swallows a falling edge
    // on that tick. A write to an unknown index must change nothing.
    set_ranging(24'd0, 16'd0, 24'd0, 24'd0, 16'd1);
    write_reg(CfgNoReg, 24'h5A5A5A);
    queue_pattern(32'b0101100, 7);
    drain();

    // Short period under the longest pulse, a zero divisor giving the all-ones
    // distance, a rising edge while the timer runs, and a falling edge that
    // arrives after the timeout.
    set_ranging(24'd4, 16'hFFFF, 24'd6, 24'hFFFFFF, 16'd0);
    queue_pattern(32'b0110110011111110, 16);
    drain();

    // Longest period and timeout; one echo inside the accept limit and one
    // that runs past it and reads as zero.
    set_ranging(24'hFFFFFF, 16'd3, 24'hFFFFFF, 24'd2, 16'd1);
    queue_pattern(32'b1010, 4);
    drain();

    // Random phases: mostly well-formed echo pulses of random length around the
    // timeout and accept limits, with bursts of random levels mixed in.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      per = (ph == 3) ? 24'd1 : 24'($urandom_range(2, 120));
      pul = 16'($urandom_range(1, 40));
      tmo = (ph == 2) ? 24'hFFFFFF : 24'($urandom_range(5, 60));
      if (ph == 0) acc = 24'hFFFFFF;
      else if (ph == 1) acc = '0;
      else if (ph == 2) acc = 24'($urandom_range(20, 90));
      else acc = 24'($urandom_range(0, tmo + 5));
      tpc = (ph == 0) ? 16'hFFFF : 16'($urandom_range(1, 16));
      set_ranging(per, pul, tmo, acc, tpc);
      // One phase runs with neither side idling at all.
      calm = (ph == 4);
      n = 0;
      while (n < TicksPerPhase) begin
        if ($urandom_range(99) < 80) begin
          len = $urandom_range(1, 8);
          repeat (len) queue_level(1'b0);
          n += len;
          len = $urandom_range(1, (tmo > 70) ? 80 : tmo + 5);
          repeat (len) queue_level(1'b1);
          n += len;
          queue_level(1'b0);
          n++;
        end else begin
          len = $urandom_range(1, 6);
          repeat (len) queue_level(1'($urandom_range(1)));
          n += len;
        end
        // Mid-phase pause of the sender until the core has caught up.
        if (ph == 1 && n >= TicksPerPhase / 2 && n < TicksPerPhase / 2 + 90) begin
          drain();
          n += 90;
          n -= 90;
        end
      end
      drain();
      calm = 1'b0;
    end

    // Let any stray result surface before the verdict.
    repeat (DivLatency + 4) @(posedge clk_i);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run of a few hundred microseconds.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/uer_pkg.sv
hw/rtl/uer_div.sv
hw/rtl/uer_datapath.sv
hw/rtl/uer_ctrl.sv
hw/rtl/ultrasonic_echo_ranging_core.sv
tb/sv/ultrasonic_echo_ranging_core_test.sv
